@@ sv/svmt_pkg.sv @@
// svmt_pkg: shared types, constants and helpers of the servo move tracker
// used by svmt_front, svmt_time, svmt_back and servo_move_tracker_top
package svmt_pkg;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 4;
    localparam int RAW_W   = 16;
    localparam int POS_W   = 10;
    localparam int TIME_W  = 16;
    localparam int STAMP_W = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 32;

    localparam int SERVO_COUNT_DEF   = 8;
    localparam int DISTANCE_SPAN_DEF = 500;

    localparam logic [POS_W-1:0]  POS_MAX        = 10'd1000;
    localparam logic [POS_W-1:0]  POS_RESET      = 10'd500;
    localparam logic [TIME_W-1:0] MIN_RESET      = 16'd100;
    localparam logic [TIME_W-1:0] MAX_RESET      = 16'd2000;
    localparam logic [POS_W-1:0]  DEADZONE_RESET = 10'd5;

    localparam logic [CMD_W-1:0] CMD_SMOOTH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DIRECT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET_ALL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd3;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QA_W   = 2;

    // reciprocal divide: product magnitude below 2^MAG_W, span below 2^10
    localparam int MAG_W     = 26;
    localparam int REC_SHIFT = 36;
    localparam int REC_W     = 37;
    localparam int REC_SPLIT = 18;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic [POS_W-1:0]   pos;
        logic [TIME_W-1:0]  mtime;
        logic [STAMP_W-1:0] now;
    } t_op;

    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] dval;
    } t_tm_req;

    typedef struct packed {
        logic              vld;
        logic [TIME_W-1:0] mtime;
    } t_tm_rsp;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [RAW_W-1:0] p);
        logic [POS_W-1:0] r;
        if (p < 0) begin
            r = '0;
        end else if (p > $signed({6'b0, POS_MAX})) begin
            r = POS_MAX;
        end else begin
            r = p[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] dist_of(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ sv/svmt_front.sv @@
// svmt_front: input beat acceptance, position clamp, id check and command queue
// depends on svmt_pkg
module svmt_front #(
    parameter int SERVO_COUNT = svmt_pkg::SERVO_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [svmt_pkg::S_DATA_W-1:0]     s_axis_tdata,
    input  logic [svmt_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              o_q_valid,
    input  logic                              i_q_ready,
    output svmt_pkg::t_op                     o_q_op
);

    svmt_pkg::t_op                 r_mem [svmt_pkg::QDEPTH];
    logic [svmt_pkg::QA_W:0]       r_cnt;
    logic [svmt_pkg::QA_W-1:0]     r_wp;
    logic [svmt_pkg::QA_W-1:0]     r_rp;

    svmt_pkg::t_op                 in_op;
    logic                          id_ok;
    logic                          keep;
    logic                          push;
    logic                          pop;

    always_comb begin
        in_op.cmd   = s_axis_tuser;
        in_op.id    = s_axis_tdata[3:0];
        in_op.pos   = svmt_pkg::clamp_pos($signed(s_axis_tdata[19:4]));
        in_op.mtime = s_axis_tdata[35:20];
        in_op.now   = s_axis_tdata[67:36];
        id_ok = (in_op.id != '0) && ({1'b0, in_op.id} <= 5'(SERVO_COUNT));
        // moves to an unknown servo are dropped here
        keep  = id_ok || (in_op.cmd == svmt_pkg::CMD_TICK)
                      || (in_op.cmd == svmt_pkg::CMD_RESET_ALL);
    end

    assign s_axis_tready = (r_cnt != (svmt_pkg::QA_W+1)'(svmt_pkg::QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign o_q_valid     = (r_cnt != '0);
    assign pop           = o_q_valid && i_q_ready;
    assign o_q_op        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ sv/svmt_time.sv @@
// svmt_time: three-stage move time unit, min + d*(max-min)/span clamped
// depends on svmt_pkg; the span divide is a split reciprocal multiply
module svmt_time #(
    parameter int DISTANCE_SPAN = svmt_pkg::DISTANCE_SPAN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  svmt_pkg::t_tm_req             i_req,
    input  logic [svmt_pkg::TIME_W-1:0]   i_min_time,
    input  logic [svmt_pkg::TIME_W-1:0]   i_max_time,
    output svmt_pkg::t_tm_rsp             o_rsp
);

    localparam int HI_W = svmt_pkg::REC_W - svmt_pkg::REC_SPLIT;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << svmt_pkg::REC_SHIFT) + 64'(DISTANCE_SPAN) - 64'd1) / 64'(DISTANCE_SPAN);
    localparam logic [svmt_pkg::REC_W-1:0] RECIP = RECIP64[svmt_pkg::REC_W-1:0];
    localparam logic [HI_W-1:0] REC_HI = RECIP[svmt_pkg::REC_W-1:svmt_pkg::REC_SPLIT];
    localparam logic [svmt_pkg::REC_SPLIT-1:0] REC_LO = RECIP[svmt_pkg::REC_SPLIT-1:0];

    logic                                        r_v1, r_v2;
    logic signed [27:0]                          r_prod;
    logic                                        r_neg;
    logic [svmt_pkg::MAG_W+HI_W-1:0]             r_phi;
    logic [svmt_pkg::MAG_W+svmt_pkg::REC_SPLIT-1:0] r_plo;
    logic [svmt_pkg::TIME_W-1:0]                 r_time;
    logic                                        r_v3;

    logic signed [16:0]                          span_diff;
    logic signed [27:0]                          prod;
    logic [27:0]                                 mag_full;
    logic [svmt_pkg::MAG_W-1:0]                  mag;
    logic [63:0]                                 acc;
    logic [27:0]                                 quo;
    logic signed [28:0]                          tval;
    logic signed [28:0]                          lo_s, hi_s;

    always_comb begin
        span_diff = $signed({1'b0, i_max_time}) - $signed({1'b0, i_min_time});
        prod      = $signed({1'b0, i_req.dval}) * span_diff;
        mag_full  = r_prod[27] ? 28'(-r_prod) : 28'(r_prod);
        mag       = mag_full[svmt_pkg::MAG_W-1:0];
        acc       = 64'({r_phi, {svmt_pkg::REC_SPLIT{1'b0}}}) + 64'(r_plo);
        quo       = acc[svmt_pkg::REC_SHIFT +: 28];
        lo_s      = $signed({13'b0, i_min_time});
        hi_s      = $signed({13'b0, i_max_time});
        // truncation toward zero: divide the magnitude, then restore the sign
        tval      = r_neg ? (lo_s - $signed({1'b0, quo})) : (lo_s + $signed({1'b0, quo}));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_neg  <= r_prod[27];
        r_phi  <= mag * REC_HI;
        r_plo  <= mag * REC_LO;
        if (tval < lo_s) begin
            r_time <= i_min_time;
        end else if (tval > hi_s) begin
            r_time <= i_max_time;
        end else begin
            r_time <= tval[svmt_pkg::TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_rsp.vld   = r_v3;
    assign o_rsp.mtime = r_time;

endmodule

@@ sv/svmt_back.sv @@
// svmt_back: servo state, configuration registers, command sequencer, result register
// depends on svmt_pkg and svmt_time
module svmt_back #(
    parameter int SERVO_COUNT   = svmt_pkg::SERVO_COUNT_DEF,
    parameter int DISTANCE_SPAN = svmt_pkg::DISTANCE_SPAN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    output logic                              o_q_ready,
    input  svmt_pkg::t_op                     i_q_op,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svmt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [svmt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [svmt_pkg::M_DATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int IW = $clog2(SERVO_COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(SERVO_COUNT - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SMOOTH   = 4'd1;
    localparam logic [3:0] S_SM_WAIT  = 4'd2;
    localparam logic [3:0] S_SM_EMIT  = 4'd3;
    localparam logic [3:0] S_DIRECT   = 4'd4;
    localparam logic [3:0] S_TK_SCAN  = 4'd5;
    localparam logic [3:0] S_TK_WAIT  = 4'd6;
    localparam logic [3:0] S_RA_MAX   = 4'd7;
    localparam logic [3:0] S_RA_WAIT  = 4'd8;
    localparam logic [3:0] S_RA_EMIT  = 4'd9;

    logic [3:0]                     r_state, n_state;
    svmt_pkg::t_op                  r_op;
    logic [IW-1:0]                  r_idx;
    logic [svmt_pkg::POS_W-1:0]     r_maxd;
    logic [svmt_pkg::TIME_W-1:0]    r_t;

    logic [svmt_pkg::POS_W-1:0]     r_center;
    logic [svmt_pkg::TIME_W-1:0]    r_min_time;
    logic [svmt_pkg::TIME_W-1:0]    r_max_time;
    logic [svmt_pkg::POS_W-1:0]     r_deadzone;

    logic [svmt_pkg::POS_W-1:0]     r_cur   [SERVO_COUNT];
    logic [svmt_pkg::POS_W-1:0]     r_tgt   [SERVO_COUNT];
    logic [svmt_pkg::STAMP_W-1:0]   r_start [SERVO_COUNT];
    logic [SERVO_COUNT-1:0]         r_moving;

    logic                           r_out_valid;
    logic [svmt_pkg::ID_W-1:0]      r_out_id;
    logic [svmt_pkg::POS_W-1:0]     r_out_pos;
    logic [svmt_pkg::TIME_W-1:0]    r_out_time;
    logic                           r_out_last;

    svmt_pkg::t_tm_req              tm_req;
    svmt_pkg::t_tm_rsp              tm_rsp;

    logic [3:0]                     slot_full;
    logic [IW-1:0]                  slot;
    logic [4:0]                     idx_p1;
    logic                           idx_last;
    logic                           out_ok;
    logic                           emit_now;
    logic [svmt_pkg::POS_W-1:0]     sm_dist;
    logic [svmt_pkg::POS_W-1:0]     tk_dist;
    logic [svmt_pkg::POS_W-1:0]     ra_dist;
    logic [svmt_pkg::POS_W-1:0]     ra_peak;
    logic [svmt_pkg::POS_W-1:0]     center_pos;
    logic [svmt_pkg::STAMP_W-1:0]   elapsed;
    logic                           done_move;

    svmt_time #(
        .DISTANCE_SPAN (DISTANCE_SPAN)
    ) u_time (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tm_req),
        .i_min_time (r_min_time),
        .i_max_time (r_max_time),
        .o_rsp      (tm_rsp)
    );

    always_comb begin
        slot_full  = r_op.id - 4'd1;
        slot       = slot_full[IW-1:0];
        idx_p1     = 5'(r_idx) + 5'd1;
        idx_last   = (r_idx == LAST_IDX);
        out_ok     = !r_out_valid || m_axis_tready;
        emit_now   = out_ok && ((r_state == S_SM_EMIT) || (r_state == S_DIRECT) ||
                                (r_state == S_RA_EMIT));
        sm_dist    = svmt_pkg::dist_of(r_op.pos, r_cur[slot]);
        tk_dist    = svmt_pkg::dist_of(r_tgt[r_idx], r_cur[r_idx]);
        // reset-all measures from the raw centre value, up to 1023
        ra_dist    = svmt_pkg::dist_of(r_center, r_cur[r_idx]);
        ra_peak    = (ra_dist > r_maxd) ? ra_dist : r_maxd;
        center_pos = svmt_pkg::clamp_pos($signed({6'b0, r_center}));
        elapsed    = r_op.now - r_start[r_idx];
        done_move  = (elapsed >= {16'b0, tm_rsp.mtime});
    end

    always_comb begin
        n_state     = r_state;
        o_q_ready   = 1'b0;
        tm_req.vld  = 1'b0;
        tm_req.dval = sm_dist;
        unique case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    unique case (i_q_op.cmd)
                        svmt_pkg::CMD_SMOOTH:    n_state = S_SMOOTH;
                        svmt_pkg::CMD_DIRECT:    n_state = S_DIRECT;
                        svmt_pkg::CMD_TICK:      n_state = S_TK_SCAN;
                        svmt_pkg::CMD_RESET_ALL: n_state = S_RA_MAX;
                        default:                 n_state = S_IDLE;
                    endcase
                end
            end
            S_SMOOTH: begin
                if (sm_dist <= r_deadzone) begin
                    n_state = S_IDLE;
                end else begin
                    tm_req.vld = 1'b1;
                    n_state    = S_SM_WAIT;
                end
            end
            S_SM_WAIT: begin
                if (tm_rsp.vld) begin
                    n_state = S_SM_EMIT;
                end
            end
            S_SM_EMIT, S_DIRECT: begin
                if (out_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_TK_SCAN: begin
                tm_req.dval = tk_dist;
                if (r_moving[r_idx]) begin
                    tm_req.vld = 1'b1;
                    n_state    = S_TK_WAIT;
                end else if (idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_TK_WAIT: begin
                if (tm_rsp.vld) begin
                    n_state = idx_last ? S_IDLE : S_TK_SCAN;
                end
            end
            S_RA_MAX: begin
                tm_req.dval = ra_peak;
                if (idx_last) begin
                    tm_req.vld = 1'b1;
                    n_state    = S_RA_WAIT;
                end
            end
            S_RA_WAIT: begin
                if (tm_rsp.vld) begin
                    n_state = S_RA_EMIT;
                end
            end
            S_RA_EMIT: begin
                if (out_ok && idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_maxd      <= '0;
            r_out_valid <= 1'b0;
            r_center    <= svmt_pkg::POS_RESET;
            r_min_time  <= svmt_pkg::MIN_RESET;
            r_max_time  <= svmt_pkg::MAX_RESET;
            r_deadzone  <= svmt_pkg::DEADZONE_RESET;
            r_moving    <= '0;
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_cur[i]   <= svmt_pkg::POS_RESET;
                r_tgt[i]   <= svmt_pkg::POS_RESET;
                r_start[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    svmt_pkg::REG_CENTER:   r_center   <= i_cfg_data[svmt_pkg::POS_W-1:0];
                    svmt_pkg::REG_MIN_TIME: r_min_time <= i_cfg_data;
                    svmt_pkg::REG_MAX_TIME: r_max_time <= i_cfg_data;
                    svmt_pkg::REG_DEADZONE: r_deadzone <= i_cfg_data[svmt_pkg::POS_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_maxd <= '0;
                    if (i_q_valid) begin
                        r_op <= i_q_op;
                    end
                end
                S_SM_WAIT, S_RA_WAIT: begin
                    if (tm_rsp.vld) begin
                        r_t <= tm_rsp.mtime;
                    end
                end
                S_SM_EMIT: begin
                    if (out_ok) begin
                        r_out_id       <= r_op.id;
                        r_out_pos      <= r_op.pos;
                        r_out_time     <= r_t;
                        r_out_last     <= 1'b1;
                        r_tgt[slot]    <= r_op.pos;
                        r_start[slot]  <= r_op.now;
                        r_moving[slot] <= 1'b1;
                    end
                end
                S_DIRECT: begin
                    if (out_ok) begin
                        r_out_id       <= r_op.id;
                        r_out_pos      <= r_op.pos;
                        r_out_time     <= r_op.mtime;
                        r_out_last     <= 1'b1;
                        r_cur[slot]    <= r_op.pos;
                        r_tgt[slot]    <= r_op.pos;
                        r_start[slot]  <= r_op.now;
                        r_moving[slot] <= 1'b0;
                    end
                end
                S_TK_SCAN: begin
                    if (!r_moving[r_idx] && !idx_last) begin
                        r_idx <= idx_p1[IW-1:0];
                    end
                end
                S_TK_WAIT: begin
                    if (tm_rsp.vld) begin
                        if (done_move) begin
                            r_cur[r_idx]    <= r_tgt[r_idx];
                            r_moving[r_idx] <= 1'b0;
                        end
                        if (!idx_last) begin
                            r_idx <= idx_p1[IW-1:0];
                        end
                    end
                end
                S_RA_MAX: begin
                    r_maxd <= ra_peak;
                    r_idx  <= idx_last ? '0 : idx_p1[IW-1:0];
                end
                S_RA_EMIT: begin
                    if (out_ok) begin
                        r_out_id        <= idx_p1[svmt_pkg::ID_W-1:0];
                        r_out_pos       <= center_pos;
                        r_out_time      <= r_t;
                        r_out_last      <= idx_last;
                        r_cur[r_idx]    <= center_pos;
                        r_tgt[r_idx]    <= center_pos;
                        r_start[r_idx]  <= r_op.now;
                        r_moving[r_idx] <= 1'b0;
                        if (!idx_last) begin
                            r_idx <= idx_p1[IW-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b0, r_out_time, r_out_pos, r_out_id};
    assign m_axis_tlast  = r_out_last;

endmodule

@@ sv/servo_move_tracker_top.sv @@
// Servo move tracker, top level.
// Input stream: one beat per command (tuser = command, tdata = id, position,
// move time and time stamp). Output stream: one beat per move command sent,
// tlast marks the final beat caused by an input beat. Smooth moves inside the
// deadzone, ticks and moves to unknown ids give no output beat.
// Config channel: i_cfg_valid/o_cfg_ready with a register index and data;
// always ready, write only while the block is idle.
// Front: classifies beats into a four-entry queue, so input is taken while the
// back end works. Back: sequencer over the servo state and a three-stage move
// time unit; the back end takes a queue item only when idle. A direct move
// emits with no time request; a smooth move asks the move time unit, waits
// and emits, or ends inside the deadzone; a tick asks for each moving servo;
// reset-all finds the peak distance, asks once and emits a beat per servo.
// Results pass through one output register; when the receiver stalls the back
// end holds, the queue fills, and then s_axis_tready drops.
// Reset (synchronous, active low) sets all servos to position 500, not
// moving, and loads the register defaults; no clearing pass is needed.
// depends on svmt_pkg, svmt_front, svmt_back
module servo_move_tracker_top #(
    parameter int SERVO_COUNT   = svmt_pkg::SERVO_COUNT_DEF,
    parameter int DISTANCE_SPAN = svmt_pkg::DISTANCE_SPAN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] servo_id, [19:4] position, [35:20] move_time, [67:36] time_ms
    input  logic [svmt_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // [1:0] command
    input  logic [svmt_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] out_servo_id, [13:4] out_position, [29:14] out_move_time
    output logic [svmt_pkg::M_DATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svmt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [svmt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic          q_valid;
    logic          q_ready;
    svmt_pkg::t_op q_op;

    svmt_front #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (q_valid),
        .i_q_ready     (q_ready),
        .o_q_op        (q_op)
    );

    svmt_back #(
        .SERVO_COUNT   (SERVO_COUNT),
        .DISTANCE_SPAN (DISTANCE_SPAN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_op        (q_op),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
